>>> hdl/i2a_pkg.sv
// ============================================================================
// i2a_pkg
// Shared types, constants and the digit glyph function of the integer to
// ASCII formatter.
// ============================================================================
`default_nettype none

package i2a_pkg;

    localparam int BIN_W      = 64;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int CNT_W      = 5;

    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEX  = 3'd2;
    localparam logic [2:0] MODE_PTR  = 3'd3;
    localparam logic [2:0] MODE_LIT  = 3'd4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_A_OFS = 8'h57;

    typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PRE0,
        ST_PRE1,
        ST_SKIP,
        ST_EMIT,
        ST_LIT
    } state_t;

    // Lowercase hex glyph for one digit; decimal digits never exceed nine.
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            r = CHAR_A_OFS + {4'b0000, d};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/integer_to_ascii_formatter.sv
// ============================================================================
// integer_to_ascii_formatter
// Formats one integer as signed decimal, unsigned decimal, hex, pointer or a
// literal byte, one ASCII character per output item, most significant first.
// ============================================================================
// The block takes one input item at a time and is not ready until its last
// character has been handed to the output register. Decimal modes run the
// shared binary to BCD shifter, then drop leading zero digits at one per
// cycle (up to 19), then send one character per cycle while the output
// accepts, so dropped and sent digits always add up to twenty. Hex and
// pointer modes skip the converter: up to 15 leading zeros are removed at one
// per cycle, then one character per cycle is sent while the output accepts.
// Mode codes 5 to 7 produce no characters. A negative signed decimal value
// is preceded by a minus sign, and a literal byte is sent as it is.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int POINTER_DIGITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [63:0] value,
    input  wire logic        arg_width,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       char_out,
    output logic             last
);

    localparam int CW = i2a_pkg::CNT_W;

    i2a_pkg::state_t   state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     min_reg, min_next;
    i2a_pkg::digits_t  dig_reg, dig_next;
    logic              neg_reg, neg_next;
    logic              ptr_reg, ptr_next;
    logic [7:0]        lit_reg, lit_next;

    logic              accept;
    logic              can_load;
    logic [63:0]       u_val;
    logic [63:0]       s_val;
    logic [63:0]       mag;
    logic              dec_mode;
    logic [CW-1:0]     top_idx;
    logic [3:0]        top_dig;
    logic              dab_busy;
    i2a_pkg::digits_t  dab_bcd;

    assign u_val    = arg_width ? value : {32'h0000_0000, value[31:0]};
    assign s_val    = arg_width ? value : {{32{value[31]}}, value[31:0]};
    assign dec_mode = (mode == i2a_pkg::MODE_SDEC) || (mode == i2a_pkg::MODE_UDEC);
    assign mag      = ((mode == i2a_pkg::MODE_SDEC) && s_val[63]) ? (~s_val + 64'd1) : u_val;

    assign in_ready = (state_reg == i2a_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;
    assign top_idx  = cnt_reg - CW'(1);
    assign top_dig  = dig_reg[top_idx];

    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && dec_mode),
        .bin   (mag),
        .busy  (dab_busy),
        .bcd   (dab_bcd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        min_reg  <= min_next;
        dig_reg  <= dig_next;
        neg_reg  <= neg_next;
        ptr_reg  <= ptr_next;
        lit_reg  <= lit_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        min_next       = min_reg;
        dig_next       = dig_reg;
        neg_next       = neg_reg;
        ptr_next       = ptr_reg;
        lit_next       = lit_reg;

        unique case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = (mode == i2a_pkg::MODE_SDEC) && s_val[63];
                    ptr_next = (mode == i2a_pkg::MODE_PTR);
                    lit_next = value[7:0];
                    unique case (mode)
                        i2a_pkg::MODE_SDEC, i2a_pkg::MODE_UDEC:
                        begin
                            state_next = i2a_pkg::ST_CONV;
                        end
                        i2a_pkg::MODE_HEX:
                        begin
                            dig_next   = i2a_pkg::digits_t'({16'h0000, u_val});
                            cnt_next   = CW'(i2a_pkg::HEX_DIGITS);
                            min_next   = CW'(1);
                            state_next = i2a_pkg::ST_SKIP;
                        end
                        i2a_pkg::MODE_PTR:
                        begin
                            dig_next   = i2a_pkg::digits_t'({16'h0000, value});
                            cnt_next   = CW'(i2a_pkg::HEX_DIGITS);
                            min_next   = CW'(POINTER_DIGITS);
                            state_next = i2a_pkg::ST_PRE0;
                        end
                        i2a_pkg::MODE_LIT:
                        begin
                            state_next = i2a_pkg::ST_LIT;
                        end
                        default:
                        begin
                            state_next = i2a_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            i2a_pkg::ST_CONV:
            begin
                if (!dab_busy)
                begin
                    dig_next   = dab_bcd;
                    cnt_next   = CW'(i2a_pkg::DEC_DIGITS);
                    min_next   = CW'(1);
                    state_next = neg_reg ? i2a_pkg::ST_PRE0 : i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_PRE0:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ptr_reg ? i2a_pkg::CHAR_ZERO : i2a_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ptr_reg ? i2a_pkg::ST_PRE1 : i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_PRE1:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::CHAR_X;
                    last_next      = 1'b0;
                    state_next     = i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SKIP:
            begin
                // Drop leading zero digits down to the minimum digit count.
                if ((cnt_reg > min_reg) && (top_dig == 4'd0))
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::glyph(top_dig);
                    last_next      = (cnt_reg == CW'(1));
                    cnt_next       = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            i2a_pkg::ST_LIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = lit_reg;
                    last_next      = 1'b1;
                    state_next     = i2a_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> hdl/i2a_dabble.sv
// ============================================================================
// i2a_dabble
// Iterative binary to BCD converter: one shift-and-add-three step per cycle.
// ============================================================================
`default_nettype none

module i2a_dabble (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [i2a_pkg::BIN_W-1:0]    bin,
    output logic                              busy,
    output i2a_pkg::digits_t                  bcd
);

    localparam int STEP_W = $clog2(i2a_pkg::BIN_W);
    localparam int BCD_W  = 4 * i2a_pkg::DEC_DIGITS;

    logic                        busy_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [i2a_pkg::BIN_W-1:0]   sh_reg;
    i2a_pkg::digits_t            bcd_reg;
    i2a_pkg::digits_t            adj;
    logic [BCD_W-1:0]            adj_flat;

    // Every digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
        adj_flat = adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(i2a_pkg::BIN_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[i2a_pkg::BIN_W-2:0], 1'b0};
            bcd_reg <= i2a_pkg::digits_t'({adj_flat[BCD_W-2:0], sh_reg[i2a_pkg::BIN_W-1]});
        end
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire
